/* rtl/pmws_pkg.sv */
// Shared types, constants and scoring functions for the motif window scanner.
package pmws_pkg;

   localparam int MAX_COLUMNS = 32;
   localparam int SCORE_BITS  = 16;
   localparam int PS_W        = 23;
   localparam int OUT_W       = 22;
   localparam int POS_W       = 32;
   localparam int MW_W        = 6;
   localparam int COL_W       = 5;
   localparam int SYM_W       = 8;
   localparam int COL_SEL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int FILL_W      = $clog2(MAX_COLUMNS + 1);
   localparam int EW          = (FILL_W > MW_W) ? FILL_W : MW_W;
   localparam int CSR_IDX_W   = 2;

   localparam int REQ_DEPTH   = 2;
   localparam int REQ_PTR_W   = $clog2(REQ_DEPTH);
   localparam int REQ_CNT_W   = $clog2(REQ_DEPTH + 1);
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_WIDTH     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_THRESHOLD = CSR_IDX_W'(1);

   typedef enum logic {
      MODE_LOAD   = 1'b0,
      MODE_SYMBOL = 1'b1
   } mode_type;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   localparam logic [SYM_W-1:0] CHAR_UC = 8'h43;
   localparam logic [SYM_W-1:0] CHAR_LC = 8'h63;
   localparam logic [SYM_W-1:0] CHAR_UG = 8'h47;
   localparam logic [SYM_W-1:0] CHAR_LG = 8'h67;
   localparam logic [SYM_W-1:0] CHAR_UT = 8'h54;
   localparam logic [SYM_W-1:0] CHAR_LT = 8'h74;

   localparam logic signed [PS_W-1:0]  PS_NEG_INF = {1'b1, {(PS_W-1){1'b0}}};
   localparam logic signed [PS_W-1:0]  PS_MAX     = {1'b0, {(PS_W-1){1'b1}}};
   localparam logic signed [PS_W-1:0]  PS_MIN     = {1'b1, {(PS_W-2){1'b0}}, 1'b1};
   localparam logic signed [OUT_W-1:0] OUT_MAX    = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN    = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic signed [SCORE_BITS-1:0] SCORE_NEG_INF = {1'b1, {(SCORE_BITS-1){1'b0}}};

   typedef struct packed {
      mode_type                      mode;
      logic [1:0]                    base;
      logic                          first;
      logic                          col_ok;
      logic [COL_W-1:0]              column;
      logic [1:0]                    row;
      logic signed [SCORE_BITS-1:0]  score;
   } req_item_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } req_head_type;

   typedef struct packed {
      logic [POS_W-1:0]         start;
      logic signed [OUT_W-1:0]  score;
   } rsp_item_type;

   typedef struct packed {
      logic                 empty;
      logic [RSP_CNT_W-1:0] count;
   } rsp_status_type;

   function automatic logic [1:0] base_of(input logic [SYM_W-1:0] c);
      logic [1:0] b;
      case (c) inside
         CHAR_UC, CHAR_LC: b = BASE_C;
         CHAR_UG, CHAR_LG: b = BASE_G;
         CHAR_UT, CHAR_LT: b = BASE_T;
         default:          b = BASE_A;
      endcase
      return b;
   endfunction

   // Moves a table score into the partial-sum domain; the most negative code is minus infinity.
   function automatic logic signed [PS_W-1:0] table_to_ps(
      input logic signed [SCORE_BITS-1:0] v);
      logic signed [32:0] x;
      logic signed [PS_W-1:0] r;
      x = 33'(v);
      if (v == SCORE_NEG_INF) begin
         r = PS_NEG_INF;
      end else if (x > 33'(PS_MAX)) begin
         r = PS_MAX;
      end else if (x < 33'(PS_MIN)) begin
         r = PS_MIN;
      end else begin
         r = PS_W'(x);
      end
      return r;
   endfunction

   function automatic logic signed [PS_W-1:0] sat_add(
      input logic signed [PS_W-1:0] a,
      input logic signed [PS_W-1:0] b);
      logic signed [PS_W:0] s;
      logic signed [PS_W-1:0] r;
      s = (PS_W+1)'(a) + (PS_W+1)'(b);
      if (a == PS_NEG_INF || b == PS_NEG_INF) begin
         r = PS_NEG_INF;
      end else if (s > (PS_W+1)'(PS_MAX)) begin
         r = PS_MAX;
      end else if (s < (PS_W+1)'(PS_MIN)) begin
         r = PS_MIN;
      end else begin
         r = PS_W'(s);
      end
      return r;
   endfunction

endpackage

/* rtl/pmws_front.sv */
// Front end: takes requests, classifies them and holds them in a short queue.
module pmws_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_mode,
   input  logic [pmws_pkg::SYM_W-1:0]           req_symbol,
   input  logic                                 req_first_of_sequence,
   input  logic [pmws_pkg::COL_W-1:0]           req_column_index,
   input  logic [1:0]                           req_base_index,
   input  logic signed [pmws_pkg::SCORE_BITS-1:0] req_score_value,
   output pmws_pkg::req_head_type               head,
   input  logic                                 head_pop
);
   import pmws_pkg::*;

   req_item_type           entry_ff [REQ_DEPTH];
   req_item_type           new_item;
   logic [REQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [REQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [REQ_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   always_comb begin
      new_item.mode   = mode_type'(req_mode);
      new_item.base   = base_of(req_symbol);
      new_item.first  = req_first_of_sequence;
      new_item.col_ok = (32'(req_column_index) < 32'(MAX_COLUMNS));
      new_item.column = req_column_index;
      new_item.row    = req_base_index;
      new_item.score  = req_score_value;
   end

   assign req_full   = (count_ff == REQ_CNT_W'(REQ_DEPTH));
   assign do_push    = req_push && !req_full;
   assign do_pop     = head_pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == REQ_PTR_W'(REQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == REQ_PTR_W'(REQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* rtl/pmws_back.sv */
// Back end: score table cells, systolic partial-sum chain and window evaluation.
module pmws_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pmws_pkg::req_head_type               head,
   output logic                                 head_pop,
   input  logic [pmws_pkg::MW_W-1:0]            motif_width,
   input  logic signed [pmws_pkg::OUT_W-1:0]    score_threshold,
   input  pmws_pkg::rsp_status_type             rsp_status,
   output logic                                 rsp_write,
   output pmws_pkg::rsp_item_type               rsp_item
);
   import pmws_pkg::*;

   logic signed [SCORE_BITS-1:0] table_ff [MAX_COLUMNS][4];
   logic signed [PS_W-1:0]       ps_ff [MAX_COLUMNS];
   logic signed [PS_W-1:0]       ps_in [MAX_COLUMNS];
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic                         eval_valid_ff;
   logic [FILL_W-1:0]            eval_fill_ff;
   logic [POS_W-1:0]             eval_pos_ff;
   logic [FILL_W-1:0]            fill_cur;
   logic [POS_W-1:0]             pos_cur;
   logic                         room;
   logic                         issue;
   logic                         issue_sym;
   logic                         issue_load;
   logic [EW-1:0]                w_eff;
   logic [COL_SEL_W-1:0]         w_idx;
   logic signed [PS_W-1:0]       total;
   logic signed [PS_W-1:0]       thr_ext;
   logic                         hit;

   // A symbol may only go ahead while the result queue has a slot for it.
   assign room = (32'(rsp_status.count) + 32'(eval_valid_ff)) < 32'(RSP_DEPTH);
   assign issue      = head.valid && ((head.item.mode == MODE_LOAD) || room);
   assign issue_sym  = issue && (head.item.mode == MODE_SYMBOL);
   assign issue_load = issue && (head.item.mode == MODE_LOAD) && head.item.col_ok;
   assign head_pop   = issue;

   always_comb begin
      ps_in[0] = table_to_ps(table_ff[0][head.item.base]);
      for (int j = 1; j < MAX_COLUMNS; j++) begin
         ps_in[j] = sat_add(ps_ff[j-1], table_to_ps(table_ff[j][head.item.base]));
      end
   end

   always_comb begin
      fill_cur = head.item.first ? '0 : fill_ff;
      pos_cur  = head.item.first ? '0 : pos_ff;
      pos_in   = pos_cur + 1'b1;
      fill_in  = (32'(fill_cur) < 32'(MAX_COLUMNS)) ? fill_cur + 1'b1 : fill_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_COLUMNS; j++) begin
            ps_ff[j] <= '0;
         end
         fill_ff       <= '0;
         pos_ff        <= '0;
         eval_valid_ff <= 1'b0;
      end else begin
         eval_valid_ff <= issue_sym;
         if (issue_sym) begin
            for (int j = 0; j < MAX_COLUMNS; j++) begin
               ps_ff[j] <= ps_in[j];
            end
            fill_ff <= fill_in;
            pos_ff  <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue_sym) begin
         eval_fill_ff <= fill_in;
         eval_pos_ff  <= pos_cur;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_COLUMNS; j++) begin
         if (issue_load && (32'(head.item.column) == j)) begin
            table_ff[j][head.item.row] <= head.item.score;
         end
      end
   end

   // The chain was updated at the previous edge, so the window ending at that
   // symbol sits in the stage picked by the effective width.
   always_comb begin
      if (motif_width == '0) begin
         w_eff = EW'(1);
      end else if (32'(motif_width) > 32'(MAX_COLUMNS)) begin
         w_eff = EW'(MAX_COLUMNS);
      end else begin
         w_eff = EW'(motif_width);
      end
      w_idx   = COL_SEL_W'(w_eff - 1'b1);
      total   = ps_ff[w_idx];
      thr_ext = PS_W'(score_threshold);
      hit     = eval_valid_ff && (EW'(eval_fill_ff) >= w_eff)
                && (total != PS_NEG_INF) && (total >= thr_ext);
      rsp_item.start = eval_pos_ff - POS_W'(w_eff - 1'b1);
      if (total > PS_W'(OUT_MAX)) begin
         rsp_item.score = OUT_MAX;
      end else if (total < PS_W'(OUT_MIN)) begin
         rsp_item.score = OUT_MIN;
      end else begin
         rsp_item.score = OUT_W'(total);
      end
   end

   assign rsp_write = hit;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_COLUMNS))
      else $error("fill count above column count");
   a_sym_evaluated: assert property (@(posedge clock) disable iff (reset)
      issue_sym |=> eval_valid_ff)
      else $error("symbol issued without evaluation");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_write |-> (32'(rsp_status.count) < 32'(RSP_DEPTH) || 1'b0) ||
                    (rsp_status.count == RSP_CNT_W'(RSP_DEPTH)) == 1'b0)
      else $error("result written into a full queue");
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (issue && head.item.mode == MODE_LOAD && !$past(issue_sym)) |=> !rsp_write)
      else $error("load produced a result");
`endif

endmodule

/* rtl/pmws_rsp_queue.sv */
// Result queue between the back end and the result ports.
module pmws_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_valid,
   input  pmws_pkg::rsp_item_type        wr_item,
   input  logic                          rd_pop,
   output pmws_pkg::rsp_item_type        rd_item,
   output pmws_pkg::rsp_status_type      status
);
   import pmws_pkg::*;

   rsp_item_type          entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;
   logic                  do_pop;

   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);
   assign do_pop       = rd_pop && !status.empty;
   assign rd_item      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_valid) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !wr_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(RSP_DEPTH))
      else $error("result queue count out of range");
   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == RSP_CNT_W'(RSP_DEPTH)) |-> !wr_valid)
      else $error("write into full result queue");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !wr_valid) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not drain an entry");
`endif

endmodule

/* rtl/pssm_motif_window_scan_top.sv */
// Top level of the motif window scanner: ports, configuration registers and wiring.
//
// The scanner slides a window of motif_width symbols along a DNA byte stream and
// scores it against a table of per-column, per-base signed scores with eight
// fraction bits. A request with mode 0 writes one table entry; a request with
// mode 1 presents one symbol, and a window that is complete and scores at or
// above score_threshold is reported as its start position and its saturated
// score. Requests are taken one per clock while req_full is low: a two-entry
// request queue feeds the back end, which advances a systolic chain of per-column
// partial sums by one stage for every symbol. A result passes through the
// registered evaluation stage and waits in a four-entry result queue;
// symbols hold back only when that queue and the evaluation stage together have
// no free slot, so with results popped as they arrive the rate is one request
// per cycle. The table entries come from registers in the score cells, so an
// entry that was never loaded reads as an arbitrary value. Configuration writes
// are always accepted and are meant to be made while the block is idle.
module pssm_motif_window_scan_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_mode,
   input  logic [pmws_pkg::SYM_W-1:0]             req_symbol,
   input  logic                                   req_first_of_sequence,
   input  logic [pmws_pkg::COL_W-1:0]             req_column_index,
   input  logic [1:0]                             req_base_index,
   input  logic signed [pmws_pkg::SCORE_BITS-1:0] req_score_value,
   // result channel
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [pmws_pkg::POS_W-1:0]             rsp_start_position,
   output logic signed [pmws_pkg::OUT_W-1:0]      rsp_window_score,
   // configuration channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pmws_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pmws_pkg::OUT_W-1:0]             csr_wdata
);
   import pmws_pkg::*;

   logic [MW_W-1:0]          motif_width_ff;
   logic signed [OUT_W-1:0]  threshold_ff;
   logic                     csr_write;
   req_head_type             head;
   logic                     head_pop;
   rsp_status_type           rsp_status;
   logic                     rsp_write;
   rsp_item_type             rsp_wr_item;
   rsp_item_type             rsp_rd_item;

   // The register file never stalls a write; unknown indexes are dropped.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         motif_width_ff <= MW_W'(1);
         threshold_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MOTIF_WIDTH:     motif_width_ff <= csr_wdata[MW_W-1:0];
            CSR_SCORE_THRESHOLD: threshold_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front end: classifies each request and queues it for the back end.
   pmws_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_mode              (req_mode),
      .req_symbol            (req_symbol),
      .req_first_of_sequence (req_first_of_sequence),
      .req_column_index      (req_column_index),
      .req_base_index        (req_base_index),
      .req_score_value       (req_score_value),
      .head                  (head),
      .head_pop              (head_pop)
   );

   // Back end: table loads, the partial-sum chain and the threshold test.
   pmws_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_pop        (head_pop),
      .motif_width     (motif_width_ff),
      .score_threshold (threshold_ff),
      .rsp_status      (rsp_status),
      .rsp_write       (rsp_write),
      .rsp_item        (rsp_wr_item)
   );

   // Hits wait here until the consumer pops them.
   pmws_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (rsp_write),
      .wr_item  (rsp_wr_item),
      .rd_pop   (rsp_pop),
      .rd_item  (rsp_rd_item),
      .status   (rsp_status)
   );

   assign rsp_empty          = rsp_status.empty;
   assign rsp_start_position = rsp_rd_item.start;
   assign rsp_window_score   = rsp_rd_item.score;

endmodule
